[sv/phase_modulated_sine_nco_unit_macros.svh]
// Assertion helpers shared by the oscillator RTL.
`ifndef PHASE_MODULATED_SINE_NCO_UNIT_MACROS_SVH
`define PHASE_MODULATED_SINE_NCO_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define PMSN_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define PMSN_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[sv/pmsn_pkg.sv]
package pmsn_pkg;

   // Fixed field widths.
   localparam int unsigned MOD_W      = 16;
   localparam int unsigned SAMPLE_W   = 16;
   localparam int unsigned STEP_W     = 32;
   localparam int unsigned AMP_W      = 17;
   localparam int unsigned PHASE_W    = 32;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 32;
   localparam int unsigned ROM_ADDR_W = 9;

   // Table depth: one period of 256 entries plus the wrap entry.
   localparam int unsigned TABLE_ENTRIES = 257;

   // Register indexes on the configuration port.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PHASE_STEP = 2'd0,
      CSR_AMPLITUDE  = 2'd1
   } csr_index_type;

   // Sequencer states, one-hot.
   typedef enum logic [4:0] {
      ST_FILL  = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_RD1   = 5'b00100,
      ST_MUL   = 5'b01000,
      ST_SCALE = 5'b10000
   } state_type;

   // First quarter of the sine period in signed Q15, including the peak.
   localparam logic signed [15:0] QUARTER_WAVE [65] = '{
      16'sd0,     16'sd804,   16'sd1608,  16'sd2410,  16'sd3212,
      16'sd4011,  16'sd4808,  16'sd5602,  16'sd6393,  16'sd7179,
      16'sd7962,  16'sd8739,  16'sd9512,  16'sd10278, 16'sd11039,
      16'sd11793, 16'sd12539, 16'sd13279, 16'sd14010, 16'sd14732,
      16'sd15446, 16'sd16151, 16'sd16846, 16'sd17530, 16'sd18204,
      16'sd18868, 16'sd19519, 16'sd20159, 16'sd20787, 16'sd21403,
      16'sd22005, 16'sd22594, 16'sd23170, 16'sd23731, 16'sd24279,
      16'sd24811, 16'sd25329, 16'sd25832, 16'sd26319, 16'sd26790,
      16'sd27245, 16'sd27683, 16'sd28105, 16'sd28510, 16'sd28898,
      16'sd29268, 16'sd29621, 16'sd29956, 16'sd30273, 16'sd30571,
      16'sd30852, 16'sd31113, 16'sd31356, 16'sd31580, 16'sd31785,
      16'sd31971, 16'sd32137, 16'sd32285, 16'sd32412, 16'sd32521,
      16'sd32609, 16'sd32678, 16'sd32728, 16'sd32757, 16'sd32767
   };

   // Full-period table entry built from the quarter wave by mirroring and sign.
   function automatic logic signed [15:0] sine_value(input logic [ROM_ADDR_W-1:0] n);
      logic [6:0]         k;
      logic [6:0]         mirror;
      logic signed [15:0] v;
      k      = n[6:0];
      mirror = 7'(8'd128 - {1'b0, k});
      if (k <= 7'd64) begin
         v = QUARTER_WAVE[k];
      end else begin
         v = QUARTER_WAVE[mirror];
      end
      // The second half-period is negative; the wrap entry stays at zero.
      if (n[7] && !n[8]) begin
         v = -v;
      end
      return v;
   endfunction

endpackage

[sv/phase_modulated_sine_nco_unit.sv]
// Phase-modulated sine oscillator.
// Input channel req_*: one beat carries a signed modulation value; each beat
// yields exactly one beat on the result channel rsp_*, a signed 16-bit sample.
// Configuration channel csr_*: index 0 sets the base phase step, index 1 the
// Q16 amplitude; other indexes are ignored. csr_ready is always high; writes
// are meant to land while no item is in flight.
// Timing: the sample register is loaded in the last step, and the block
// takes a new item only once the previous one has left that step. The pace
// is set by the single read port of the sine table memory, which delivers
// the two neighboring entries on consecutive cycles, followed by the
// interpolation multiply and the amplitude multiply, each registered.
// Reset: the phase and both registers clear, then the table memory is loaded
// one entry a cycle, all TableEntries (257) of them; req_ready stays low during
// this load, while configuration writes are taken as usual.
// Stall: a finished sample waits in the output register. A new item can be
// accepted meanwhile; its sample is held back in the last step until the
// output register is free, and only then is the next item taken.
module phase_modulated_sine_nco_unit #(
   parameter int unsigned TableEntries = pmsn_pkg::TABLE_ENTRIES
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // Input item channel
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [pmsn_pkg::MOD_W-1:0]     req_modulation,
   // Result channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [pmsn_pkg::SAMPLE_W-1:0]  rsp_sample,
   // Configuration channel
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [pmsn_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [pmsn_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import pmsn_pkg::*;

   localparam int unsigned AddrWidth = $clog2(TableEntries);

   // Sequencer and control.
   state_type              state_ff, state_in;
   logic [AddrWidth-1:0]   fill_cnt_ff, fill_cnt_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   // Configuration registers.
   logic [STEP_W-1:0]      phase_step_ff;
   logic [AMP_W-1:0]       amplitude_ff;

   // Phase accumulator.
   logic [PHASE_W-1:0]     phase_ff, phase_in;

   // Table memory and its registered read port.
   logic signed [15:0]     rom_mem [TableEntries];
   logic signed [15:0]     rom_q_ff;
   logic [AddrWidth-1:0]   rd_addr;

   // Datapath registers.
   logic signed [MOD_W-1:0]    mod_ff;
   logic signed [15:0]         r0_ff;
   logic signed [48:0]         dprod_ff;
   logic signed [31:0]         acc_ff;
   logic signed [SAMPLE_W-1:0] rsp_sample_ff;

   // Datapath combinational values.
   logic [7:0]             idx;
   logic [15:0]            frac;
   logic signed [16:0]     diff;
   logic signed [33:0]     interp_prod;
   logic signed [33:0]     acc_sum;
   logic signed [48:0]     dprod;
   logic signed [49:0]     prod;
   logic signed [17:0]     y;
   logic signed [SAMPLE_W-1:0] sat_sample;
   logic                   accept;
   logic                   out_free;

   assign idx      = phase_ff[31:24];
   assign frac     = phase_ff[23:8];
   assign accept   = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;

   // Sequencer: table load after reset, then four steps per item.
   always_comb begin
      state_in     = state_ff;
      fill_cnt_in  = fill_cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_FILL: begin
            fill_cnt_in = fill_cnt_ff + AddrWidth'(1);
            if (fill_cnt_ff == AddrWidth'(TableEntries - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_RD1;
            end
         end
         ST_RD1:  state_in = ST_MUL;
         ST_MUL:  state_in = ST_SCALE;
         ST_SCALE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_FILL;
         fill_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_cnt_ff  <= fill_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Configuration writes; unknown indexes are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_step_ff <= '0;
         amplitude_ff  <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_PHASE_STEP: phase_step_ff <= csr_wdata[STEP_W-1:0];
            CSR_AMPLITUDE:  amplitude_ff  <= csr_wdata[AMP_W-1:0];
            default: ;
         endcase
      end
   end

   // Table memory: loaded during the fill pass, read one entry per cycle.
   // In idle the base entry is fetched, in the next step its neighbor.
   assign rd_addr = (state_ff == ST_IDLE) ? AddrWidth'(idx)
                                          : AddrWidth'({1'b0, idx} + 9'd1);

   always_ff @(posedge clock) begin
      if (state_ff == ST_FILL) begin
         rom_mem[fill_cnt_ff] <= sine_value(ROM_ADDR_W'(fill_cnt_ff));
      end
      rom_q_ff <= rom_mem[rd_addr];
   end

   // Modulation term of the phase step, floor-scaled later by the bit select.
   assign dprod = $signed({1'b0, phase_step_ff}) * mod_ff;

   // Linear interpolation: r0 * 2^16 + (r1 - r0) * frac, which is Q31.
   assign diff        = 17'(rom_q_ff) - 17'(r0_ff);
   assign interp_prod = diff * $signed({1'b0, frac});
   assign acc_sum     = $signed({{2{r0_ff[15]}}, r0_ff, 16'b0}) + interp_prod;

   // Phase advance by step plus the floored modulation term, modulo 2^32.
   assign phase_in = phase_ff + phase_step_ff + dprod_ff[46:15];

   // Amplitude scaling with floor shift by 32 and saturation.
   assign prod = acc_ff * $signed({1'b0, amplitude_ff});
   assign y    = prod[49:32];
   always_comb begin
      if (y > 18'sd32767) begin
         sat_sample = 16'sh7fff;
      end else if (y < -18'sd32768) begin
         sat_sample = -16'sh8000;
      end else begin
         sat_sample = y[15:0];
      end
   end

   // Phase register.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
      end else if (state_ff == ST_MUL) begin
         phase_ff <= phase_in;
      end
   end

   // Payload registers along the item's steps.
   always_ff @(posedge clock) begin
      if (accept) begin
         mod_ff <= req_modulation;
      end
      if (state_ff == ST_RD1) begin
         r0_ff    <= rom_q_ff;
         dprod_ff <= dprod;
      end
      if (state_ff == ST_MUL) begin
         acc_ff <= acc_sum[31:0];
      end
      if (state_ff == ST_SCALE && out_free) begin
         rsp_sample_ff <= sat_sample;
      end
   end

   assign req_ready  = (state_ff == ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_sample = rsp_sample_ff;
   assign csr_ready  = 1'b1;

   // Checks on the sequencer and the phase update.
`include "phase_modulated_sine_nco_unit_macros.svh"

   `PMSN_ASSERT_NOW(a_no_accept_in_fill, clock, reset, state_ff == ST_FILL, !req_ready, "item taken during table load")
   `PMSN_ASSERT_NEXT(a_accept_starts_item, clock, reset, accept, state_ff == ST_RD1, "accepted item did not start")
   `PMSN_ASSERT_NEXT(a_stall_holds_result, clock, reset, state_ff == ST_SCALE && !out_free, state_ff == ST_SCALE && rsp_sample == $past(rsp_sample), "result overwritten while stalled")
   `PMSN_ASSERT_NEXT(a_phase_only_in_mul, clock, reset, state_ff != ST_MUL, $stable(phase_ff), "phase moved outside its update step")

endmodule
